### rtl/assert_macros.svh
// Assertion macros shared by the parser and output register modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("synchronous assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/msp_pkg.sv
// Types, status codes and helpers for the MIDI stream parser.
package msp_pkg;

    // Status byte codes
    localparam logic [7:0] RT_FIRST      = 8'hf8;
    localparam logic [7:0] RT_TIMING_CLK = 8'hf8;
    localparam logic [7:0] RT_SEQ_START  = 8'hfa;
    localparam logic [7:0] RT_CONTINUE   = 8'hfb;
    localparam logic [7:0] RT_STOP       = 8'hfc;
    localparam logic [7:0] SYS_FIRST     = 8'hf0;
    localparam logic [7:0] SYS_EX        = 8'hf0;
    localparam logic [7:0] SYS_MTC       = 8'hf1;
    localparam logic [7:0] SYS_SONG_POS  = 8'hf2;
    localparam logic [7:0] SYS_SONG_SEL  = 8'hf3;
    localparam logic [7:0] RS_RESET      = 8'h90;

    // Channel message kinds (high nibble of status)
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'ha;
    localparam logic [3:0] HI_CTRL       = 4'hb;
    localparam logic [3:0] HI_PROG       = 4'hc;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hd;
    localparam logic [3:0] HI_PITCH      = 4'he;

    // Channel select value meaning "learn from traffic" / "not learned"
    localparam logic [4:0] CHAN_LEARN = 5'd16;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_KEY_ON,
        EV_KEY_OFF,
        EV_SONG_POS,
        EV_CLOCK,
        EV_START,
        EV_CONTINUE,
        EV_STOP
    } t_event_kind;

    typedef struct packed {
        logic        thru_valid;
        logic [7:0]  thru_byte;
        t_event_kind event_kind;
        logic [6:0]  key_note;
        logic [6:0]  key_velocity;
        logic [13:0] song_position;
    } t_result;

    // Results caused by one byte, entry 0 goes out first
    typedef struct packed {
        logic [1:0]                  cnt;
        t_result [MAX_RESULTS-1:0]   ent;
    } t_run;

    // Result that forwards one byte on the thru output
    function automatic t_result fwd_res(input logic [7:0] b);
        t_result r;
        r = '0;
        r.thru_valid = 1'b1;
        r.thru_byte  = b;
        return r;
    endfunction

endpackage

### rtl/msp_parser.sv
// Running status parser: holds message state and builds the result run per byte.
`include "assert_macros.svh"

module msp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [4:0]     i_cfg_data,
    input  logic           i_item_valid,
    input  logic [7:0]     i_byte,
    output msp_pkg::t_run  o_run
);
    import msp_pkg::*;

    logic [4:0] r_chan_sel;
    logic [7:0] r_running,  n_running;
    logic [1:0] r_count,    n_count;
    logic [6:0] r_data0,    n_data0;
    logic [6:0] r_data1,    n_data1;
    logic [4:0] r_learned,  n_learned;
    t_run       run;

    // Decode one byte against the current state
    always_comb begin
        logic [7:0] st;
        logic [1:0] cnt;
        logic [6:0] d0;
        logic [6:0] d1;
        logic [3:0] hi;
        logic [3:0] listen;
        logic       mine;

        n_learned = r_learned;
        run       = '0;
        st        = r_running;
        cnt       = r_count;
        d0        = r_data0;
        d1        = r_data1;
        hi        = st[7:4];
        listen    = r_chan_sel[3:0];
        mine      = 1'b0;

        if (i_byte >= RT_FIRST) begin
            // real-time: echo and leave the message state alone
            run.cnt    = 2'd1;
            run.ent[0] = fwd_res(i_byte);
            case (i_byte)
                RT_TIMING_CLK: run.ent[0].event_kind = EV_CLOCK;
                RT_SEQ_START:  run.ent[0].event_kind = EV_START;
                RT_CONTINUE:   run.ent[0].event_kind = EV_CONTINUE;
                RT_STOP:       run.ent[0].event_kind = EV_STOP;
                default:       run.ent[0].event_kind = EV_NONE;
            endcase
        end else begin
            if (i_byte[7]) begin
                st  = i_byte;
                cnt = 2'd0;
            end else if (cnt < 2'd2) begin
                if (cnt[0]) begin
                    d1 = i_byte[6:0];
                end else begin
                    d0 = i_byte[6:0];
                end
                cnt = cnt + 2'd1;
            end
            hi = st[7:4];

            if (st >= SYS_FIRST) begin
                case (st)
                    SYS_EX: begin
                        // every SysEx byte goes out alone
                        run.cnt = 2'd1;
                        if (cnt == 2'd0) begin
                            run.ent[0] = fwd_res(st);
                        end else if (cnt == 2'd1) begin
                            run.ent[0] = fwd_res({1'b0, d0});
                        end else begin
                            run.ent[0] = fwd_res({1'b0, d1});
                        end
                        cnt = 2'd1;
                    end
                    SYS_SONG_POS: begin
                        if (cnt >= 2'd2) begin
                            run.cnt                  = 2'd1;
                            run.ent[0].event_kind    = EV_SONG_POS;
                            run.ent[0].song_position = {d1, d0};
                            cnt = 2'd0;
                        end
                    end
                    SYS_MTC, SYS_SONG_SEL: begin
                        if (cnt >= 2'd1) begin
                            run.cnt    = 2'd2;
                            run.ent[0] = fwd_res(st);
                            run.ent[1] = fwd_res({1'b0, d0});
                            cnt = 2'd0;
                        end
                    end
                    default: begin
                        // end of SysEx, tune request, undefined codes
                        cnt = 2'd0;
                    end
                endcase
            end else begin
                // channel message: pick the listened channel, learning if asked
                if (r_chan_sel[4]) begin
                    if (r_learned[4]) begin
                        n_learned = {1'b0, st[3:0]};
                    end
                    listen = n_learned[3:0];
                end
                mine = (st[3:0] == listen);

                if (hi inside {HI_PROG, HI_CHAN_PRESS}) begin
                    if (cnt >= 2'd1) begin
                        run.cnt    = 2'd2;
                        run.ent[0] = fwd_res(st);
                        run.ent[1] = fwd_res({1'b0, d0});
                        cnt = 2'd0;
                    end
                end else if (cnt >= 2'd2) begin
                    if (mine && hi == HI_NOTE_ON && d1 != 7'd0) begin
                        run.cnt                 = 2'd1;
                        run.ent[0].event_kind   = EV_KEY_ON;
                        run.ent[0].key_note     = d0;
                        run.ent[0].key_velocity = d1;
                    end else if (mine && hi inside {HI_NOTE_ON, HI_NOTE_OFF}) begin
                        run.cnt               = 2'd1;
                        run.ent[0].event_kind = EV_KEY_OFF;
                        run.ent[0].key_note   = d0;
                    end else if (mine && hi == HI_CTRL) begin
                        run.cnt = 2'd0;
                    end else begin
                        run.cnt    = 2'd3;
                        run.ent[0] = fwd_res(st);
                        run.ent[1] = fwd_res({1'b0, d0});
                        run.ent[2] = fwd_res({1'b0, d1});
                    end
                    cnt = 2'd0;
                end
            end
        end

        n_running = st;
        n_count   = cnt;
        n_data0   = d0;
        n_data1   = d1;
    end

    assign o_run = run;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_sel <= CHAN_LEARN;
            r_running  <= RS_RESET;
            r_count    <= 2'd0;
            r_learned  <= CHAN_LEARN;
        end else begin
            if (i_cfg_we) begin
                r_chan_sel <= i_cfg_data;
            end
            if (i_item_valid) begin
                r_running <= n_running;
                r_count   <= n_count;
                r_learned <= n_learned;
            end
        end
    end

    // Held data bytes, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_item_valid) begin
            r_data0 <= n_data0;
            r_data1 <= n_data1;
        end
    end

    // Every message handler leaves at most one data byte pending
    `ASSERT_NEVER(a_count_below_two, i_clk, i_rst_n, r_count[1])
    // A learned channel is kept
    `ASSERT_SYNC(a_learned_sticks, i_clk, i_rst_n, !r_learned[4] |=> !r_learned[4])
    // Real-time bytes do not disturb message state
    `ASSERT_SYNC(a_rt_keeps_state, i_clk, i_rst_n,
        (i_item_valid && i_byte >= RT_FIRST) |=> ($stable(r_running) && $stable(r_count)))

endmodule

### rtl/msp_out_seq.sv
// Output register: holds the result run of one byte and hands it out one per transaction.
`include "assert_macros.svh"

module msp_out_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_en,
    input  msp_pkg::t_run    i_run,
    input  logic             i_stall,
    output logic             o_can_load,
    output logic             o_valid,
    output msp_pkg::t_result o_result,
    output logic             o_last
);
    import msp_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_ent [MAX_RESULTS];
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && !i_stall;
    // free now, or its last result leaves this cycle
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_ent[0];
    assign o_last     = (r_cnt == 2'd1);

    // Remaining result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load_en) begin
            r_cnt <= i_run.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result payload, shifts toward entry 0 on each transaction
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_ent[0] <= i_run.ent[0];
            r_ent[1] <= i_run.ent[1];
            r_ent[2] <= i_run.ent[2];
        end else if (pop) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

    // More results pending keeps the output valid
    `ASSERT_SYNC(a_run_continues, i_clk, i_rst_n,
        (pop && (r_cnt == 2'd2 || r_cnt == 2'd3)) |=> o_valid)
    // A new run never overwrites results not yet taken
    `ASSERT_SYNC(a_no_overwrite, i_clk, i_rst_n,
        i_load_en |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && !i_stall)))
    // A byte with no results leaves nothing on the output
    `ASSERT_SYNC(a_empty_run, i_clk, i_rst_n,
        (i_load_en && i_run.cnt == 2'd0) |=> !o_valid)

endmodule

### rtl/midi_stream_parser_thru_core.sv
// Top level of the MIDI stream parser with thru forwarding.
// One received MIDI byte per input transaction; each byte yields zero to three
// results (forwarded thru bytes or events), the last one flagged by o_last_of_run.
// A byte is held in the input register, parsed in a single pass, and its results
// are loaded into the output register and go out one per output transaction.
// Unless the result side stalls, bytes with at most one result are taken every
// cycle; a byte with two or three results holds the output register until its
// last one is taken, stalling the input. Channel select must be written over the
// configuration port only while the block is idle, which the block does not
// enforce; 16 and up makes it learn its channel from the first channel message.
module midi_stream_parser_thru_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // received bytes
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_thru_valid,
    output logic [7:0]  o_thru_byte,
    output logic [2:0]  o_event_kind,
    output logic [6:0]  o_key_note,
    output logic [6:0]  o_key_velocity,
    output logic [13:0] o_song_position,
    output logic        o_last_of_run
);
    import msp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       advance;
    logic       rx_accept;
    t_run       run;
    t_result    res;

    assign o_cfg_ready = 1'b1;

    // Input register
    assign advance    = r_in_valid && can_load;
    assign o_rx_stall = r_in_valid && !can_load;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    msp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (advance),
        .i_byte       (r_in_byte),
        .o_run        (run)
    );

    msp_out_seq u_out_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_en  (advance),
        .i_run      (run),
        .i_stall    (i_res_stall),
        .o_can_load (can_load),
        .o_valid    (o_res_valid),
        .o_result   (res),
        .o_last     (o_last_of_run)
    );

    // Result fields
    assign o_thru_valid    = res.thru_valid;
    assign o_thru_byte     = res.thru_byte;
    assign o_event_kind    = res.event_kind;
    assign o_key_note      = res.key_note;
    assign o_key_velocity  = res.key_velocity;
    assign o_song_position = res.song_position;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the MIDI stream parser: queued byte driver, result monitor, predictor.
module testbench;
    import msp_pkg::*;

    localparam logic [7:0] SYS_UNDEF_F4 = 8'hf4;
    localparam logic [7:0] SYS_UNDEF_F5 = 8'hf5;
    localparam logic [7:0] SYS_TUNE     = 8'hf6;
    localparam logic [7:0] SYS_EOX      = 8'hf7;
    localparam logic [7:0] RT_LAST      = 8'hff;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AT_BYTE  = 45;
    localparam int HOLD_CYCLES   = 200;

    typedef struct {
        t_result res;
        logic    last;
    } t_parsed_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_res_stall = 1'b0;
    logic        o_cfg_ready;
    logic        o_rx_stall;
    logic        o_res_valid;
    logic        o_thru_valid;
    logic [7:0]  o_thru_byte;
    logic [2:0]  o_event_kind;
    logic [6:0]  o_key_note;
    logic [6:0]  o_key_velocity;
    logic [13:0] o_song_position;
    logic        o_last_of_run;

    midi_stream_parser_thru_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_thru_valid   (o_thru_valid),
        .o_thru_byte    (o_thru_byte),
        .o_event_kind   (o_event_kind),
        .o_key_note     (o_key_note),
        .o_key_velocity (o_key_velocity),
        .o_song_position(o_song_position),
        .o_last_of_run  (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // Bytes waiting to be sent, and parser outputs still owed by the block
    logic [7:0]  rx_bytes_q [$];
    t_parsed_out parsed_q [$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          rx_taken = 0;
    int          bytes_queued = 0;

    // Predictor state
    logic [4:0]  chan_sel_m = CHAN_LEARN;
    logic [7:0]  run_status_m = RS_RESET;
    logic [1:0]  data_cnt_m = '0;
    logic [6:0]  data_m [2];
    logic [4:0]  learned_ch_m = CHAN_LEARN;

    function automatic t_result make_out(input logic v, input logic [7:0] b,
                                         input t_event_kind k, input logic [6:0] note,
                                         input logic [6:0] vel, input logic [13:0] pos);
        t_result r;
        r.thru_valid    = v;
        r.thru_byte     = b;
        r.event_kind    = k;
        r.key_note      = note;
        r.key_velocity  = vel;
        r.song_position = pos;
        return r;
    endfunction

    // Parse one received byte and queue the outputs it should cause
    function automatic void parse_rx_byte(input logic [7:0] b);
        t_result     outs [$];
        t_parsed_out po;
        t_event_kind kind;
        logic [7:0]  st;
        logic [1:0]  cnt;
        logic [1:0]  prev;
        logic [3:0]  ch;
        logic [3:0]  hi;
        logic [4:0]  listen;
        logic        mine;
        if (b >= RT_FIRST) begin
            case (b)
                RT_TIMING_CLK: kind = EV_CLOCK;
                RT_SEQ_START:  kind = EV_START;
                RT_CONTINUE:   kind = EV_CONTINUE;
                RT_STOP:       kind = EV_STOP;
                default:       kind = EV_NONE;
            endcase
            outs.push_back(make_out(1'b1, b, kind, '0, '0, '0));
        end else begin
            if (b[7]) begin
                run_status_m = b;
                data_cnt_m = '0;
            end else if (data_cnt_m < 2) begin
                data_m[data_cnt_m[0]] = b[6:0];
                data_cnt_m = data_cnt_m + 2'd1;
            end
            st = run_status_m;
            cnt = data_cnt_m;
            if (st >= SYS_FIRST) begin
                case (st)
                    SYS_EX: begin
                        prev = cnt - 2'd1;
                        if (cnt == 0) outs.push_back(make_out(1'b1, st, EV_NONE, '0, '0, '0));
                        else outs.push_back(make_out(1'b1, {1'b0, data_m[prev[0]]},
                                                     EV_NONE, '0, '0, '0));
                        cnt = 2'd1;
                    end
                    SYS_SONG_POS: begin
                        if (cnt >= 2) begin
                            outs.push_back(make_out(1'b0, '0, EV_SONG_POS, '0, '0,
                                                    {data_m[1], data_m[0]}));
                            cnt = '0;
                        end
                    end
                    SYS_MTC, SYS_SONG_SEL: begin
                        if (cnt >= 1) begin
                            outs.push_back(make_out(1'b1, st, EV_NONE, '0, '0, '0));
                            outs.push_back(make_out(1'b1, {1'b0, data_m[0]}, EV_NONE,
                                                    '0, '0, '0));
                            cnt = '0;
                        end
                    end
                    default: cnt = '0;
                endcase
            end else begin
                ch = st[3:0];
                hi = st[7:4];
                if (chan_sel_m < CHAN_LEARN) begin
                    listen = chan_sel_m;
                end else begin
                    if (learned_ch_m >= CHAN_LEARN) learned_ch_m = {1'b0, ch};
                    listen = learned_ch_m;
                end
                mine = ({1'b0, ch} == listen);
                if (hi == HI_PROG || hi == HI_CHAN_PRESS) begin
                    if (cnt >= 1) begin
                        outs.push_back(make_out(1'b1, st, EV_NONE, '0, '0, '0));
                        outs.push_back(make_out(1'b1, {1'b0, data_m[0]}, EV_NONE,
                                                '0, '0, '0));
                        cnt = '0;
                    end
                end else if (cnt >= 2) begin
                    if (mine && hi == HI_NOTE_ON && data_m[1] != 0) begin
                        outs.push_back(make_out(1'b0, '0, EV_KEY_ON, data_m[0], data_m[1], '0));
                    end else if (mine && (hi == HI_NOTE_ON || hi == HI_NOTE_OFF)) begin
                        outs.push_back(make_out(1'b0, '0, EV_KEY_OFF, data_m[0], '0, '0));
                    end else if (!(mine && hi == HI_CTRL)) begin
                        // anything not consumed here goes out on thru
                        outs.push_back(make_out(1'b1, st, EV_NONE, '0, '0, '0));
                        outs.push_back(make_out(1'b1, {1'b0, data_m[0]}, EV_NONE,
                                                '0, '0, '0));
                        outs.push_back(make_out(1'b1, {1'b0, data_m[1]}, EV_NONE,
                                                '0, '0, '0));
                    end
                    cnt = '0;
                end
            end
            data_cnt_m = cnt;
        end
        foreach (outs[i]) begin
            po.res  = outs[i];
            po.last = (i == outs.size() - 1);
            parsed_q.push_back(po);
        end
    endfunction

    // Queue one byte, now and then with a real-time byte slipped in ahead of it
    function automatic void put_byte(input logic [7:0] b);
        if ($urandom_range(0, 15) == 0) begin
            rx_bytes_q.push_back(8'($urandom_range(RT_FIRST, RT_LAST)));
            bytes_queued++;
        end
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endfunction

    // Mostly well-formed messages with random content, plus broken ones and noise
    task automatic queue_traffic(input int n);
        int         base;
        int         pick;
        int         k;
        logic [3:0] hi;
        logic [3:0] ch;
        logic [4:0] listen;
        logic [7:0] chan_status;
        bit         have_status;
        base = bytes_queued;
        have_status = 1'b0;
        chan_status = RS_RESET;
        while (bytes_queued - base < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                listen = (chan_sel_m < CHAN_LEARN) ? chan_sel_m : learned_ch_m;
                // running status: sometimes leave the status byte out
                if (!(have_status && $urandom_range(0, 3) == 0)) begin
                    hi = 4'($urandom_range(HI_NOTE_OFF, HI_PITCH));
                    if (listen < CHAN_LEARN && $urandom_range(0, 1) == 1) ch = listen[3:0];
                    else ch = 4'($urandom_range(0, 15));
                    chan_status = {hi, ch};
                    have_status = 1'b1;
                    put_byte(chan_status);
                end
                put_byte(8'($urandom_range(0, 127)));
                if (chan_status[7:4] != HI_PROG && chan_status[7:4] != HI_CHAN_PRESS) begin
                    if ($urandom_range(0, 4) == 0) put_byte(8'h00);
                    else put_byte(8'($urandom_range(0, 127)));
                end
            end else if (pick < 68) begin
                have_status = 1'b0;
                k = $urandom_range(0, 5);
                case (k)
                    0: begin
                        put_byte(SYS_SONG_POS);
                        put_byte(8'($urandom_range(0, 127)));
                        put_byte(8'($urandom_range(0, 127)));
                        if ($urandom_range(0, 2) == 0) begin
                            put_byte(8'($urandom_range(0, 127)));
                            put_byte(8'($urandom_range(0, 127)));
                        end
                    end
                    1: begin
                        put_byte(SYS_MTC);
                        put_byte(8'($urandom_range(0, 127)));
                    end
                    2: begin
                        put_byte(SYS_SONG_SEL);
                        put_byte(8'($urandom_range(0, 127)));
                        if ($urandom_range(0, 2) == 0) put_byte(8'($urandom_range(0, 127)));
                    end
                    3: begin
                        put_byte(SYS_EX);
                        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 127)));
                        if ($urandom_range(0, 4) != 0) put_byte(SYS_EOX);
                    end
                    4: begin
                        put_byte(8'($urandom_range(SYS_UNDEF_F4, SYS_EOX)));
                        if ($urandom_range(0, 1) == 1) put_byte(8'($urandom_range(0, 127)));
                    end
                    default: begin
                        // song position cut short
                        put_byte(SYS_SONG_POS);
                        put_byte(8'($urandom_range(0, 127)));
                    end
                endcase
            end else if (pick < 80) begin
                put_byte(8'($urandom_range(RT_FIRST, RT_LAST)));
            end else begin
                have_status = 1'b0;
                put_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Wait until every byte is sent and every output has come back
    task automatic wait_idle();
        while (!(rx_bytes_q.size() == 0 && !i_rx_valid && parsed_q.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_channel_select(input logic [4:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        chan_sel_m = v;
    endtask

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Byte driver: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                parse_rx_byte(i_rx_byte);
                rx_taken++;
            end
            if (!i_rx_valid || !o_rx_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_rx_valid <= 1'b0;
                end else if (rx_bytes_q.size() > 0) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= rx_bytes_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side once, so the block backs up into its input
    logic hold_off = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    always @(posedge i_clk) begin
        if (!hold_done && rx_taken >= HOLD_AT_BYTE) begin
            hold_off  <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_off <= 1'b0;
        end
    end

    // Result monitor: checks each transaction, stalls on a changing pattern
    int stall_mode = 0;
    int mode_left = 0;
    t_parsed_out want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else begin
            if (o_res_valid && !i_res_stall) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected output: expected none, actual byte 0x%0h kind %0d",
                             $time, o_thru_byte, o_event_kind);
                    fail_cnt++;
                end else begin
                    want = parsed_q.pop_front();
                    cmp_field("thru_valid", 32'(want.res.thru_valid), 32'(o_thru_valid));
                    cmp_field("thru_byte", 32'(want.res.thru_byte), 32'(o_thru_byte));
                    cmp_field("event_kind", 32'(want.res.event_kind), 32'(o_event_kind));
                    cmp_field("key_note", 32'(want.res.key_note), 32'(o_key_note));
                    cmp_field("key_velocity", 32'(want.res.key_velocity),
                              32'(o_key_velocity));
                    cmp_field("song_position", 32'(want.res.song_position),
                              32'(o_song_position));
                    cmp_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 60);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       i_res_stall <= hold_off;
                1:       i_res_stall <= hold_off || ($urandom_range(0, 3) == 0);
                default: i_res_stall <= hold_off || ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus phases; channel select is only changed while the block is idle
    initial begin
        logic [7:0] opening [29];
        opening = '{8'h3c, 8'h40,                     // data under reset status: learn, key on
                    8'h3c, 8'h00,                     // velocity zero is key off
                    {HI_NOTE_OFF, 4'h0}, 8'h7f, 8'h7f,
                    {HI_PITCH, 4'h5}, 8'h00, RT_SEQ_START, 8'h7f,
                    {HI_CTRL, 4'h0}, 8'h07, 8'h64,    // control change swallowed
                    {HI_PROG, 4'hf}, 8'h05,
                    SYS_SONG_POS, 8'h7f, 8'h7f, 8'h00, 8'h00,
                    SYS_SONG_SEL, 8'h05,
                    SYS_EX, 8'h01, SYS_EOX,
                    SYS_TUNE, RT_TIMING_CLK, RT_STOP};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (opening[i]) begin
            rx_bytes_q.push_back(opening[i]);
            bytes_queued++;
        end
        queue_traffic(24);
        wait_idle();
        write_channel_select(5'd31);
        queue_traffic(18);
        wait_idle();
        write_channel_select(5'd0);
        queue_traffic(18);
        wait_idle();
        write_channel_select(5'd15);
        queue_traffic(18);
        wait_idle();
        write_channel_select(5'($urandom_range(0, 31)));
        queue_traffic(18);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && parsed_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_parser.sv
rtl/msp_out_seq.sv
rtl/midi_stream_parser_thru_core.sv
tb/testbench.sv
